[src/cpsp_pkg.sv]
// Package: payload types, register indexes and shared constants for the cascaded PID pair.
package cpsp_pkg;

  typedef struct packed {
    logic signed [15:0] delta_a;
    logic signed [15:0] delta_b;
    logic signed [31:0] target_position;
  } cpsp_in_t;

  typedef struct packed {
    logic signed [31:0] drive_a;
    logic signed [31:0] drive_b;
    logic               done_res;
  } cpsp_out_t;

  localparam int          DoneTolerance = 6554;
  localparam int unsigned MulSteps      = 32;

  localparam logic [2:0] RegPosKp  = 3'd0;
  localparam logic [2:0] RegPosKi  = 3'd1;
  localparam logic [2:0] RegPosKd  = 3'd2;
  localparam logic [2:0] RegVelKp  = 3'd3;
  localparam logic [2:0] RegVelKi  = 3'd4;
  localparam logic [2:0] RegVelKd  = 3'd5;
  localparam logic [2:0] RegSpdLim = 3'd6;
  localparam logic [2:0] RegStpLim = 3'd7;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] v, input int bits);
    logic signed [63:0] lim;
    lim = 64'sd1 <<< (bits - 1);
    if (v > lim - 64'sd1) return lim - 64'sd1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [63:0] clamp_term(input logic signed [79:0] v);
    logic signed [79:0] lim;
    lim = 80'sd1 <<< 61;
    if (v > lim) return 64'sd1 <<< 61;
    if (v < -lim) return -(64'sd1 <<< 61);
    return v[63:0];
  endfunction

endpackage

[src/cpsp_mul.sv]
// Bit-serial signed 32x48 multiplier giving floor(g*v/65536), one gain bit per cycle.
module cpsp_mul import cpsp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] gain,
  input  logic signed [47:0] value,
  output logic               busy,
  output logic signed [63:0] term
);
  logic               busy_r, busy_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [31:0]        g_r, g_nxt;
  logic signed [79:0] v_r, v_nxt;
  logic signed [79:0] acc_r, acc_nxt;
  logic signed [79:0] prod;

  assign prod = acc_r >>> 16;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    g_nxt    = g_r;
    v_nxt    = v_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      g_nxt    = gain;
      v_nxt    = 80'(value);
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (g_r[0]) begin
        if (cnt_r == 6'(MulSteps - 1)) acc_nxt = acc_r - v_r;
        else acc_nxt = acc_r + v_r;
      end
      g_nxt = g_r >> 1;
      v_nxt = v_r <<< 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(MulSteps - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    g_r   <= g_nxt;
    v_r   <= v_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign term = clamp_term(prod);
endmodule

[src/cascaded_position_speed_pid_pair.sv]
// Top level: cascaded position/speed PID pair for one axis with two opposed wheels.
// Usage:
//   in_ channel carries one control tick (wheel deltas and target position).
//   out_ channel returns one result per tick: two drives and a done flag.
//   cfg_ channel writes gains and limits by index; write only while idle.
//   Each tick runs nine products on one bit-serial multiplier (each one
//   started, run over its 32 gain bits and accumulated): three position
//   products, then the command clamp, the speed error setup, six speed
//   products and the result load into the output register.
//   One item is in flight at a time: no new transfer is taken until the result is loaded.
//   The result sits in an output register; the next input transfer is
//   taken as soon as the result is loaded there, so a stalled receiver
//   holds only the previous result, and a new result waits until it leaves.
//   Synchronous reset clears all loop state, the gain and limit registers and the handshakes.
//   When the position error falls under the tolerance, the drives are zero,
//   done is set and all loop state clears.
module cascaded_position_speed_pid_pair import cpsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cpsp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cpsp_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  typedef enum logic [2:0] {S_IDLE, S_POS, S_CMD, S_VEL, S_FIN, S_OUT} state_t;

  state_t state_r;
  logic [3:0] step_r;
  logic       mstart_r;

  logic signed [31:0] kp_r, ki_r, kd_r, vkp_r, vki_r, vkd_r;
  logic [30:0]        slim_r, stlim_r;
  logic signed [63:0] slim_s, stlim_s;

  logic signed [47:0] pos_sum_r, pint_r, iint_a_r, iint_b_r;
  logic signed [31:0] lperr_r, lcmd_r, lea_r, leb_r;

  logic signed [31:0] perr_r, cmd_r, ea_r, eb_r, da_r, db_r;
  logic signed [32:0] dperr_r;
  logic signed [63:0] sum_r;
  logic signed [31:0] drive_a_r;
  logic signed [47:0] npos_r, npint_r, nia_r, nib_r;

  logic               out_valid_r;
  cpsp_out_t          out_r;

  logic signed [31:0] mgain;
  logic signed [47:0] mval;
  logic               mbusy;
  logic signed [63:0] mterm;

  logic signed [63:0] t_sum, t_perr, t_cmd, t_diff, t_ea, t_eb;
  logic signed [63:0] t_pint, t_nia, t_nib;

  cpsp_mul u_mul (
    .clk, .rst_n, .start(mstart_r), .gain(mgain), .value(mval),
    .busy(mbusy), .term(mterm)
  );

  always_comb begin
    case (step_r)
      4'd0: begin mgain = kp_r;  mval = 48'(perr_r);  end
      4'd1: begin mgain = ki_r;  mval = npint_r;       end
      4'd2: begin mgain = kd_r;  mval = 48'(dperr_r); end
      4'd3: begin mgain = vkp_r; mval = 48'(ea_r);    end
      4'd4: begin mgain = vki_r; mval = nia_r;         end
      4'd5: begin mgain = vkd_r; mval = 48'(ea_r) - 48'(lea_r); end
      4'd6: begin mgain = vkp_r; mval = 48'(eb_r);    end
      4'd7: begin mgain = vki_r; mval = nib_r;         end
      default: begin mgain = vkd_r; mval = 48'(eb_r) - 48'(leb_r); end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slim_s  = 64'($signed({1'b0, slim_r}));
  assign stlim_s = 64'($signed({1'b0, stlim_r}));

  always_comb begin
    t_sum  = sat64(64'(pos_sum_r) + 64'(in_data.delta_a) - 64'(in_data.delta_b), 48);
    t_perr = sat64(64'(in_data.target_position) - (t_sum <<< 15), 32);
    t_pint = sat64(64'(pint_r) + t_perr, 48);
    t_cmd  = sat64(sum_r, 32);
    if (t_cmd > slim_s) t_cmd = slim_s;
    if (t_cmd < -slim_s) t_cmd = -slim_s;
    t_diff = t_cmd - 64'(lcmd_r);
    if (t_diff > stlim_s) t_cmd = sat64(64'(lcmd_r) + stlim_s, 32);
    else if (t_diff < -stlim_s) t_cmd = sat64(64'(lcmd_r) - stlim_s, 32);
    t_ea = sat64(64'(cmd_r) - (64'(da_r) <<< 16), 32);
    t_eb = sat64(-64'(cmd_r) - (64'(db_r) <<< 16), 32);
    t_nia = sat64(64'(iint_a_r) + t_ea, 48);
    t_nib = sat64(64'(iint_b_r) + t_eb, 48);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      mstart_r <= 1'b0;
      out_valid_r <= 1'b0;
      kp_r <= '0; ki_r <= '0; kd_r <= '0;
      vkp_r <= '0; vki_r <= '0; vkd_r <= '0;
      slim_r <= '0; stlim_r <= '0;
      pos_sum_r <= '0; pint_r <= '0; iint_a_r <= '0; iint_b_r <= '0;
      lperr_r <= '0; lcmd_r <= '0; lea_r <= '0; leb_r <= '0;
    end else begin
      mstart_r <= 1'b0;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          RegPosKp:  kp_r <= cfg_wdata;
          RegPosKi:  ki_r <= cfg_wdata;
          RegPosKd:  kd_r <= cfg_wdata;
          RegVelKp:  vkp_r <= cfg_wdata;
          RegVelKi:  vki_r <= cfg_wdata;
          RegVelKd:  vkd_r <= cfg_wdata;
          RegSpdLim: slim_r <= cfg_wdata[30:0];
          RegStpLim: stlim_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            npos_r  <= t_sum[47:0];
            perr_r  <= t_perr[31:0];
            npint_r <= t_pint[47:0];
            dperr_r <= 33'(t_perr - 64'(lperr_r));
            da_r <= 32'(in_data.delta_a);
            db_r <= 32'(in_data.delta_b);
            sum_r <= '0;
            step_r <= '0;
            mstart_r <= 1'b1;
            state_r <= S_POS;
          end
        end
        S_POS: begin
          if (!mstart_r && !mbusy) begin
            if (step_r == 4'd2) begin
              sum_r <= sum_r + mterm;
              state_r <= S_CMD;
            end else begin
              sum_r <= sum_r + mterm;
              step_r <= step_r + 4'd1;
              mstart_r <= 1'b1;
            end
          end
        end
        S_CMD: begin
          cmd_r <= t_cmd[31:0];
          state_r <= S_VEL;
          step_r <= 4'd15;
        end
        S_VEL: begin
          if (step_r == 4'd15) begin
            ea_r <= t_ea[31:0];
            eb_r <= t_eb[31:0];
            nia_r <= t_nia[47:0];
            nib_r <= t_nib[47:0];
            sum_r <= '0;
            step_r <= 4'd3;
            mstart_r <= 1'b1;
          end else if (!mstart_r && !mbusy) begin
            if (step_r == 4'd5) begin
              drive_a_r <= 32'(sat64(sum_r + mterm, 32));
              sum_r <= '0;
            end else begin
              sum_r <= sum_r + mterm;
            end
            if (step_r == 4'd8) begin
              state_r <= S_FIN;
            end else begin
              step_r <= step_r + 4'd1;
              mstart_r <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            if (perr_r > -DoneTolerance && perr_r < DoneTolerance) begin
              out_r.drive_a <= '0;
              out_r.drive_b <= '0;
              out_r.done_res <= 1'b1;
              pos_sum_r <= '0; pint_r <= '0; iint_a_r <= '0; iint_b_r <= '0;
              lperr_r <= '0; lcmd_r <= '0; lea_r <= '0; leb_r <= '0;
            end else begin
              out_r.drive_a <= drive_a_r;
              out_r.drive_b <= 32'(sat64(sum_r, 32));
              out_r.done_res <= 1'b0;
              pos_sum_r <= npos_r; pint_r <= npint_r;
              iint_a_r <= nia_r; iint_b_r <= nib_r;
              lperr_r <= perr_r; lcmd_r <= cmd_r;
              lea_r <= ea_r; leb_r <= eb_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("transfer taken while busy");
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.done_res) |-> (out_data.drive_a == 0 && out_data.drive_b == 0))
    else $error("done with nonzero drive");
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mbusy) else $error("multiplier busy while idle");
endmodule

[tb/sv/tb.sv]
// Testbench for the cascaded position/speed PID pair: random and directed ticks checked
// against a behavioral predictor.
module tb;
  import cpsp_pkg::*;

  localparam int WatchdogLimit = 30000;
  localparam int LongHold      = 1500;
  localparam longint TermLim   = 64'sd1 <<< 61;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cpsp_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  cpsp_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  cascaded_position_speed_pid_pair dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gains and limits as the block holds them
  longint pos_kp, pos_ki, pos_kd, vel_kp, vel_ki, vel_kd, spd_lim, stp_lim;
  // loop state
  longint axis_sum, prev_perr, perr_integ, prev_cmd, prev_ea, prev_eb, integ_a, integ_b;

  cpsp_out_t drive_queue[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic longint sat_to(longint v, int bits);
    longint lim;
    lim = 64'sd1 <<< (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint q16_product(longint g, longint v);
    longint hi, lo, p;
    hi = v >>> 16;
    lo = v - (hi <<< 16);
    p = g * hi + ((g * lo) >>> 16);
    if (p > TermLim) p = TermLim;
    if (p < -TermLim) p = -TermLim;
    return p;
  endfunction

  function automatic longint pid_out(longint kp, longint ki, longint kd,
                                     longint e, longint integ, longint de);
    return sat_to(q16_product(kp, e) + q16_product(ki, integ) + q16_product(kd, de), 32);
  endfunction

  function automatic void clear_loop();
    axis_sum = 0; prev_perr = 0; perr_integ = 0; prev_cmd = 0;
    prev_ea = 0; prev_eb = 0; integ_a = 0; integ_b = 0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      RegPosKp:  pos_kp = longint'(signed'(val));
      RegPosKi:  pos_ki = longint'(signed'(val));
      RegPosKd:  pos_kd = longint'(signed'(val));
      RegVelKp:  vel_kp = longint'(signed'(val));
      RegVelKi:  vel_ki = longint'(signed'(val));
      RegVelKd:  vel_kd = longint'(signed'(val));
      RegSpdLim: spd_lim = longint'(val[30:0]);
      RegStpLim: stp_lim = longint'(val[30:0]);
      default: ;
    endcase
  endfunction

  function automatic cpsp_out_t predict_drives(cpsp_in_t t);
    longint da, db, perr, dperr, cmd, diff, ea, eb, da_out, db_out;
    cpsp_out_t r;
    da = longint'(t.delta_a);
    db = longint'(t.delta_b);
    axis_sum = sat_to(axis_sum + (da - db), 48);
    perr = sat_to(longint'(t.target_position) - axis_sum * 32768, 32);
    perr_integ = sat_to(perr_integ + perr, 48);
    dperr = perr - prev_perr;
    prev_perr = perr;
    cmd = pid_out(pos_kp, pos_ki, pos_kd, perr, perr_integ, dperr);
    if (cmd > spd_lim) cmd = spd_lim;
    if (cmd < -spd_lim) cmd = -spd_lim;
    diff = cmd - prev_cmd;
    if (diff > stp_lim) cmd = sat_to(prev_cmd + stp_lim, 32);
    else if (diff < -stp_lim) cmd = sat_to(prev_cmd - stp_lim, 32);
    prev_cmd = cmd;
    ea = sat_to(cmd - da * 65536, 32);
    eb = sat_to(-cmd - db * 65536, 32);
    integ_a = sat_to(integ_a + ea, 48);
    integ_b = sat_to(integ_b + eb, 48);
    da_out = pid_out(vel_kp, vel_ki, vel_kd, ea, integ_a, ea - prev_ea);
    db_out = pid_out(vel_kp, vel_ki, vel_kd, eb, integ_b, eb - prev_eb);
    prev_ea = ea;
    prev_eb = eb;
    if ((perr < 0 ? -perr : perr) < longint'(DoneTolerance)) begin
      clear_loop();
      r.drive_a = '0;
      r.drive_b = '0;
      r.done_res = 1'b1;
    end else begin
      r.drive_a = da_out[31:0];
      r.drive_b = db_out[31:0];
      r.done_res = 1'b0;
    end
    return r;
  endfunction

  task automatic send_tick(cpsp_in_t t);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!(in_valid && !in_stall));
    drive_queue.push_back(predict_drives(t));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    wait (drive_queue.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_reg(idx, val);
  endtask

  task automatic load_gains(logic [31:0] g[8]);
    for (int i = 0; i < 8; i++) write_reg(3'(i), g[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cpsp_in_t near_target(int spread);
    cpsp_in_t t;
    t.delta_a = 16'(signed'($urandom_range(40)) - 20);
    t.delta_b = 16'(signed'($urandom_range(40)) - 20);
    t.target_position = 32'(sat_to((axis_sum + longint'(t.delta_a) - longint'(t.delta_b))
                        * 32768 + longint'($urandom_range(2 * spread)) - spread, 32));
    return t;
  endfunction

  function automatic cpsp_in_t wild_tick();
    cpsp_in_t t;
    t.delta_a = 16'($urandom);
    t.delta_b = 16'($urandom);
    t.target_position = 32'($urandom);
    return t;
  endfunction

  function automatic cpsp_in_t mk_tick(int da, int db, int tp);
    cpsp_in_t t;
    t.delta_a = 16'(da);
    t.delta_b = 16'(db);
    t.target_position = 32'(tp);
    return t;
  endfunction

  task automatic test_zero_gains();
    send_tick(mk_tick(0, 0, 0));
    send_tick(mk_tick(0, 0, 6553));
    send_tick(mk_tick(0, 0, -6553));
    send_tick(mk_tick(0, 0, 6554));
    send_tick(mk_tick(0, 0, -6554));
    send_tick(mk_tick(32767, -32768, 32'sh7fffffff));
    end_burst();
  endtask

  task automatic test_extreme_gains();
    logic [31:0] g[8];
    g = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff};
    load_gains(g);
    send_tick(mk_tick(32767, -32768, 32'sh7fffffff));
    send_tick(mk_tick(32767, -32768, 32'sh7fffffff));
    send_tick(mk_tick(-32768, 32767, 32'sh80000000));
    send_tick(mk_tick(-32768, 32767, 32'sh80000000));
    send_tick(mk_tick(0, 0, 0));
    end_burst();
    g = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h80000000, 32'h00000000, 32'h00000000};
    load_gains(g);
    send_tick(mk_tick(100, -100, 32'sh80000000));
    send_tick(mk_tick(-32768, 32767, 32'sh7fffffff));
    send_tick(mk_tick(32767, 32767, 12345678));
    end_burst();
    g = '{32'h00010000, 32'h00000100, 32'h00001000, 32'h00020000,
          32'h00000400, 32'h00000800, 32'h00050000, 32'h00000800};
    load_gains(g);
    for (int i = 0; i < 6; i++) send_tick(mk_tick(3, -3, 5000000));
    send_tick(mk_tick(0, 0, -5000000));
    send_tick(mk_tick(0, 0, 32'(axis_sum * 32768)));
    end_burst();
  endtask

  task automatic test_backpressure();
    logic [31:0] g[8];
    g = '{32'h00008000, 32'h00000080, 32'h00000800, 32'h00010000,
          32'h00000200, 32'h00000400, 32'h00100000, 32'h00004000};
    load_gains(g);
    tx_idle_pct = 0;
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++) send_tick(near_target(400000));
    end_burst();
  endtask

  task automatic test_random(int n);
    logic [31:0] g[8];
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 6; i++)
        g[i] = ($urandom_range(9) == 0) ? $urandom : 32'(signed'($urandom_range(262144)) - 65536);
      g[6] = ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h00400000);
      g[7] = ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h00040000);
      load_gains(g);
      for (int i = 0; i < n / 4; i++) begin
        if ($urandom_range(9) < 2) send_tick(wild_tick());
        else send_tick(near_target($urandom_range(1) ? 8000 : 300000));
      end
      end_burst();
    end
  endtask

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (drive_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        cpsp_out_t e;
        e = drive_queue.pop_front();
        if (out_data.drive_a !== e.drive_a) begin
          $display("%0t: drive_a expected %0d actual %0d", $time, e.drive_a, out_data.drive_a);
          errors++;
        end
        if (out_data.drive_b !== e.drive_b) begin
          $display("%0t: drive_b expected %0d actual %0d", $time, e.drive_b, out_data.drive_b);
          errors++;
        end
        if (out_data.done_res !== e.done_res) begin
          $display("%0t: done_res expected %0b actual %0b", $time, e.done_res, out_data.done_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    pos_kp = 0; pos_ki = 0; pos_kd = 0; vel_kp = 0; vel_ki = 0; vel_kd = 0;
    spd_lim = 0; stp_lim = 0;
    clear_loop();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 23;
    rx_idle_pct = 75;
    test_zero_gains();
    test_extreme_gains();
    test_random(160);
    tx_idle_pct = 75;
    rx_idle_pct = 23;
    test_random(160);
    test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(160);
    repeat (400) @(posedge clk);
    if (errors == 0 && drive_queue.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

[files.f]
src/cpsp_pkg.sv
src/cpsp_mul.sv
src/cascaded_position_speed_pid_pair.sv
tb/sv/tb.sv
